// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define CHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/jicc_pkg.sv =====
// Shared types, constants and the ICC signature table for the JPEG ICC scanner.
// No dependencies; every rtl module file imports this package.
package jicc_pkg;

    localparam logic [7:0]  BYTE_FF     = 8'hFF;
    localparam logic [7:0]  BYTE_SOI    = 8'hD8;
    localparam logic [7:0]  MARK_APP2   = 8'hE2;
    localparam logic [31:0] SPACE_RGB   = 32'h5247_4220;
    localparam logic [15:0] ICC_MIN_LEN = 16'd14;
    localparam logic [15:0] ICC_SIG_LEN = 16'd12;
    localparam logic [15:0] SIG_FIRST   = 16'd2;
    localparam logic [15:0] SPACE_FIRST = 16'd32;
    localparam logic [15:0] SPACE_LAST  = 16'd35;

    typedef enum logic [2:0] {
        CAUSE_FOUND   = 3'd0,
        CAUSE_NOTJPEG = 3'd1,
        CAUSE_MARKER  = 3'd2,
        CAUSE_LENGTH  = 3'd3,
        CAUSE_EOF     = 3'd4
    } cause_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
        logic       last_of_file;
    } in_item_t;

    typedef struct packed {
        logic   is_srgb;
        cause_t cause;
    } result_t;

    // Expected byte of the ICC segment tag (eleven characters plus NUL) at position idx
    function automatic logic [7:0] icc_tag_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h49;
            4'd1:    b = 8'h43;
            4'd2:    b = 8'h43;
            4'd3:    b = 8'h5F;
            4'd4:    b = 8'h50;
            4'd5:    b = 8'h52;
            4'd6:    b = 8'h4F;
            4'd7:    b = 8'h46;
            4'd8:    b = 8'h49;
            4'd9:    b = 8'h4C;
            4'd10:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/jicc_in_stage.sv =====
// Input register for the byte channel of the JPEG ICC scanner.
// Depends on jicc_pkg for the item struct.
module jicc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               first_of_file,
    input  logic               last_of_file,
    input  logic               out_free,
    output logic               step,
    output jicc_pkg::in_item_t item
);
    import jicc_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    in_item_t item_reg;
    logic     accept;

    // Stall only while a held byte cannot move on
    assign byte_stall = hold_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;
    assign step       = hold_valid_reg && out_free;
    assign item       = item_reg;

    // Fill on accept, drain when the byte is consumed
    always_comb
    begin
        if (accept)
            hold_valid_next = 1'b1;
        else if (out_free)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= '{data_byte: data_byte, first_of_file: first_of_file,
                          last_of_file: last_of_file};
    end

endmodule

// ===== rtl/jicc_scan.sv =====
// Marker segment walker: start marker, segment headers, ICC signature and
// colour-space capture. Depends on jicc_pkg.
module jicc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  jicc_pkg::in_item_t item,
    output logic               res_valid,
    output jicc_pkg::result_t  res
);
    import jicc_pkg::*;

    typedef enum logic [3:0] {
        PH_START0 = 4'd0,
        PH_START1 = 4'd1,
        PH_MARK0  = 4'd2,
        PH_MARK1  = 4'd3,
        PH_LEN0   = 4'd4,
        PH_LEN1   = 4'd5,
        PH_BODY   = 4'd6
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [15:0] offset_reg,  offset_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  marker_reg,  marker_next;
    logic        sig_ok_reg,  sig_ok_next;
    logic [31:0] space_reg,   space_next;
    logic        decided_reg, decided_next;

    // One byte step: start from cleared state on a new file, then advance
    always_comb
    begin
        logic        hit;
        cause_t      cause;
        logic [16:0] off_inc;
        logic [15:0] full_len;
        logic        icc_seg;
        logic [3:0]  sig_idx;
        logic [31:0] space_shift;

        phase_next   = phase_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        marker_next  = marker_reg;
        sig_ok_next  = sig_ok_reg;
        space_next   = space_reg;
        decided_next = decided_reg;
        if (item.first_of_file)
        begin
            phase_next   = PH_START0;
            offset_next  = '0;
            length_next  = '0;
            marker_next  = '0;
            sig_ok_next  = 1'b1;
            space_next   = '0;
            decided_next = 1'b0;
        end

        hit         = 1'b0;
        cause       = CAUSE_EOF;
        off_inc     = {1'b0, offset_next} + 17'd1;
        full_len    = {length_next[15:8], item.data_byte};
        icc_seg     = (marker_next == MARK_APP2) && (length_next > ICC_MIN_LEN);
        sig_idx     = offset_next[3:0] - SIG_FIRST[3:0];
        space_shift = {space_next[23:0], item.data_byte};

        if (!decided_next)
        begin
            case (phase_next)
                PH_START0:
                begin
                    if (item.data_byte != BYTE_FF)
                    begin
                        hit   = 1'b1;
                        cause = CAUSE_NOTJPEG;
                    end
                    else
                        phase_next = PH_START1;
                end
                PH_START1:
                begin
                    if (item.data_byte != BYTE_SOI)
                    begin
                        hit   = 1'b1;
                        cause = CAUSE_NOTJPEG;
                    end
                    else
                        phase_next = PH_MARK0;
                end
                PH_MARK0:
                begin
                    if (item.data_byte != BYTE_FF)
                    begin
                        hit   = 1'b1;
                        cause = CAUSE_MARKER;
                    end
                    else
                        phase_next = PH_MARK1;
                end
                PH_MARK1:
                begin
                    marker_next = item.data_byte;
                    sig_ok_next = 1'b1;
                    space_next  = '0;
                    phase_next  = PH_LEN0;
                end
                PH_LEN0:
                begin
                    length_next = {item.data_byte, 8'h00};
                    phase_next  = PH_LEN1;
                end
                PH_LEN1:
                begin
                    length_next = full_len;
                    if (full_len < 16'd2)
                    begin
                        hit   = 1'b1;
                        cause = CAUSE_LENGTH;
                    end
                    else if (full_len == 16'd2)
                    begin
                        offset_next = '0;
                        phase_next  = PH_MARK0;
                    end
                    else
                    begin
                        offset_next = 16'd2;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (icc_seg)
                    begin
                        // Check signature bytes
                        if (offset_next >= SIG_FIRST &&
                            offset_next < SIG_FIRST + ICC_SIG_LEN &&
                            item.data_byte != icc_tag_byte(sig_idx))
                            sig_ok_next = 1'b0;
                        // Shift in colour-space bytes
                        if (offset_next >= SPACE_FIRST && offset_next <= SPACE_LAST)
                        begin
                            space_next = space_shift;
                            if (offset_next == SPACE_LAST && sig_ok_next &&
                                space_shift == SPACE_RGB)
                            begin
                                hit   = 1'b1;
                                cause = CAUSE_FOUND;
                            end
                        end
                    end
                    // Leave the segment after its last byte
                    if (off_inc >= {1'b0, length_next})
                    begin
                        phase_next  = PH_MARK0;
                        offset_next = '0;
                    end
                    else
                        offset_next = off_inc[15:0];
                end
                default:
                begin
                    hit   = 1'b1;
                    cause = CAUSE_MARKER;
                end
            endcase

            if (!hit && item.last_of_file)
            begin
                hit   = 1'b1;
                cause = CAUSE_EOF;
            end
            if (hit)
                decided_next = 1'b1;
        end

        res_valid   = step && hit;
        res.is_srgb = (cause == CAUSE_FOUND);
        res.cause   = cause;
    end

    // Hold scan state; advance only on a consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START0;
            offset_reg  <= '0;
            length_reg  <= '0;
            marker_reg  <= '0;
            sig_ok_reg  <= 1'b1;
            space_reg   <= '0;
            decided_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            marker_reg  <= marker_next;
            sig_ok_reg  <= sig_ok_next;
            space_reg   <= space_next;
            decided_reg <= decided_next;
        end
    end

endmodule

// ===== rtl/jicc_out_stage.sv =====
// Result register for the JPEG ICC scanner output channel.
// Depends on jicc_pkg for the result struct.
module jicc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jicc_pkg::result_t res,
    output logic              out_free,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              is_srgb,
    output logic [2:0]        stop_cause
);
    import jicc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Register is free when empty or being taken this cycle
    assign out_free     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign is_srgb      = res_reg.is_srgb;
    assign stop_cause   = res_reg.cause;

    always_comb
    begin
        if (out_free)
            valid_next = load;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load a new result; hold while stalled
    always_ff @(posedge clk)
    begin
        if (load && out_free)
            res_reg <= res;
    end

endmodule

// ===== rtl/jpeg_icc_colour_space_detector.sv =====
// JPEG embedded-ICC colour space detector.
// Byte channel: byte_valid/byte_stall with data_byte, first_of_file and
// last_of_file; one file byte per word, first_of_file restarts the scan.
// Result channel: result_valid/result_stall with is_srgb and stop_cause
// (found, not jpeg, bad marker, bad length, end of file). At most one
// result per file; later bytes of a decided file are swallowed.
// Throughput: one byte per cycle while the result register is free, set by
// the segment walker between the input register and the result register.
// Path: a deciding byte is held in the input register, then its result is
// loaded into the result register when that register is free.
// Stall: while a result waits under result_stall, at most one more byte is taken
// into the input register, then byte_stall rises until the result leaves.
// Reset (rst_n low, asynchronous) empties both registers and sets the
// scan to expect the start marker of a new file.
// Depends on jicc_pkg, jicc_in_stage, jicc_scan and jicc_out_stage.
module jpeg_icc_colour_space_detector (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       first_of_file,
    input  logic       last_of_file,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       is_srgb,
    output logic [2:0] stop_cause
);
    import jicc_pkg::*;

    in_item_t item;
    result_t  res;
    logic     step;
    logic     res_valid;
    logic     out_free;

    // Hold the incoming byte
    jicc_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .first_of_file (first_of_file),
        .last_of_file  (last_of_file),
        .out_free      (out_free),
        .step          (step),
        .item          (item)
    );

    // Advance the segment walk
    jicc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Register the decision
    jicc_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_valid),
        .res          (res),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .is_srgb      (is_srgb),
        .stop_cause   (stop_cause)
    );

endmodule

// ===== rtl/jicc_checker.sv =====
// Port-level checks for the JPEG ICC colour space detector, bound to the top.
// Depends on jicc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jicc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic       is_srgb,
    input logic [2:0] stop_cause
);
    import jicc_pkg::*;

    // A stalled result holds
    `CHK_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(is_srgb) && $stable(stop_cause))

    // The sRGB flag goes only with the found cause
    `CHK_ASSERT_IMP(a_srgb_cause, result_valid,
        is_srgb == (stop_cause == CAUSE_FOUND))

    // Only the five defined causes appear
    `CHK_ASSERT_IMP(a_cause_range, result_valid,
        stop_cause == CAUSE_FOUND || stop_cause == CAUSE_NOTJPEG ||
        stop_cause == CAUSE_MARKER || stop_cause == CAUSE_LENGTH ||
        stop_cause == CAUSE_EOF)

    // The byte side stalls only behind a blocked result
    `CHK_ASSERT_IMP(a_stall_cause, byte_stall, result_valid && result_stall)

    // Bytes held off stay held off while the result stays blocked
    `CHK_ASSERT_NEXT(a_stall_persist, byte_stall, byte_stall || !result_stall)

endmodule

bind jpeg_icc_colour_space_detector jicc_checker u_jicc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_srgb      (is_srgb),
    .stop_cause   (stop_cause)
);
